FILE: hw/rtl/tbpf_pkg.sv
// Shared types and constants for the tile background pixel fetcher.
`timescale 1ns / 1ps

package tbpf_pkg;

	// Video memory and pixel queue geometry.
	localparam int VRAM_BYTES  = 8192;
	localparam int VRAM_AW     = $clog2(VRAM_BYTES);
	localparam int FIFO_DEPTH  = 16;
	localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
	localparam int TILE_PIXELS = 8;

	// Item commands.
	typedef enum logic [1:0] {
		CMD_FETCH_TICK = 2'd0,
		CMD_PIXEL_POP  = 2'd1,
		CMD_VRAM_WRITE = 2'd2,
		CMD_LINE_START = 2'd3
	} cmd_t;

	// Configuration register indexes.
	localparam logic [2:0] REG_BG_MAP_HIGH        = 3'd0;
	localparam logic [2:0] REG_WIN_MAP_HIGH       = 3'd1;
	localparam logic [2:0] REG_WIN_ENABLE         = 3'd2;
	localparam logic [2:0] REG_UNSIGNED_TILE_DATA = 3'd3;
	localparam logic [2:0] REG_SCROLL_Y           = 3'd4;
	localparam logic [2:0] REG_WIN_Y              = 3'd5;
	localparam logic [2:0] REG_WIN_X              = 3'd6;

	// Fetcher steps that do work; the others only advance.
	localparam logic [2:0] PH_TILE = 3'd0;
	localparam logic [2:0] PH_LOW  = 3'd2;
	localparam logic [2:0] PH_HIGH = 3'd4;
	localparam logic [2:0] PH_PUSH = 3'd5;

	// The window start column is the register value minus this offset, or zero when the value is below it.
	localparam logic [7:0] WIN_X_OFFSET = 8'd7;

	// Tile maps sit at 0x1800 and 0x1C00: the top two address bits are set.
	localparam logic [1:0] MAP_REGION = 2'b11;

	// Which byte the memory returns in the cycle after a fetch step read.
	typedef enum logic [1:0] {
		LD_NONE = 2'd0,
		LD_TILE = 2'd1,
		LD_LOW  = 2'd2,
		LD_HIGH = 2'd3
	} load_t;

endpackage

FILE: hw/rtl/tbpf_ram.sv
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps

module tbpf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One access per cycle; read data holds until the next read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

FILE: hw/rtl/tile_background_pixel_fetcher.sv
// Top level of the background and window tile fetcher with its pixel queue.
`timescale 1ns / 1ps

// The block takes one command per clock while not stalled (fetch tick, pixel
// pop, video memory write or line start) and returns one result per command,
// registered, in the cycle after the transfer. Throughput is one item every
// cycle while not stalled: every fetch step makes at most one access to the
// single-port 8 KiB memory, and a byte read is forwarded until captured.
// The result register stalls the input only while a result waits and the
// output side stalls. The video memory is not cleared at reset and needs no
// clearing pass; bytes must be written before the fetcher reads them.
// Configuration may be written at any time the block is idle.
module tile_background_pixel_fetcher (
	input  logic                          clk,
	input  logic                          arst_n,
	// Configuration write channel.
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [2:0]                    cfg_index,
	input  logic [7:0]                    cfg_data,
	// Item channel.
	input  logic                          item_valid,
	output logic                          item_stall,
	input  logic [1:0]                    command,
	input  logic [7:0]                    line_y,
	input  logic [7:0]                    screen_x,
	input  logic [7:0]                    window_row,
	input  logic [tbpf_pkg::VRAM_AW-1:0]  mem_addr,
	input  logic [7:0]                    mem_data,
	input  logic [7:0]                    start_pos,
	input  logic [1:0]                    startup_count,
	// Result channel.
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [1:0]                    pixel,
	output logic                          pixel_valid,
	output logic                          pop_empty,
	output logic [4:0]                    fifo_level,
	output logic                          in_window,
	output logic [2:0]                    fetch_phase
);

	import tbpf_pkg::*;

	// Configuration registers.
	logic       bg_map_high_q;
	logic       win_map_high_q;
	logic       win_enable_q;
	logic       unsigned_tile_data_q;
	logic [7:0] scroll_y_q;
	logic [7:0] win_y_q;
	logic [7:0] win_x_q;

	// Fetcher and queue state.
	logic [2:0]         phase_q;
	logic               window_on_q;
	logic [7:0]         fetch_pos_q;
	logic [7:0]         tile_id_q;
	logic [2:0]         tile_row_q;
	logic [7:0]         row_lo_q;
	logic [7:0]         row_hi_q;
	logic [1:0]         fifo_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] head_q;
	logic [FIFO_AW:0]   count_q;
	logic [1:0]         startup_q;
	load_t              load_q;

	// Result register.
	logic       result_valid_q;
	logic [1:0] pixel_q;
	logic       pixel_valid_q;
	logic       pop_empty_q;

	// Memory port.
	logic               ram_we;
	logic               ram_re;
	logic [VRAM_AW-1:0] ram_addr;
	logic [7:0]         ram_rdata;

	// Next-state values.
	logic               accept;
	cmd_t               cmd;
	logic [7:0]         win_start_x;
	logic               win_trigger;
	logic [2:0]         phase_e;
	logic [7:0]         pos_e;
	logic [FIFO_AW:0]   count_e;
	logic [1:0]         startup_e;
	logic [7:0]         bg_line;
	logic [7:0]         map_line;
	logic               map_high;
	logic               tile_hi_bit;
	logic [7:0]         tile_id_eff;
	logic [7:0]         row_lo_eff;
	logic [7:0]         row_hi_eff;
	logic               startup_push;
	logic               push_en;
	logic               tile_row_we;
	logic [2:0]         tile_row_d;
	logic [2:0]         phase_d;
	logic               window_on_d;
	logic [7:0]         fetch_pos_d;
	logic [FIFO_AW-1:0] head_d;
	logic [FIFO_AW:0]   count_d;
	logic [1:0]         startup_d;
	load_t              load_d;
	logic [1:0]         pixel_d;
	logic               pixel_valid_d;
	logic               pop_empty_d;

	assign cmd        = cmd_t'(command);
	assign item_stall = result_valid_q & result_stall;
	assign accept     = item_valid & ~item_stall;
	assign cfg_ready  = 1'b1;

	// Bytes read in the previous cycle are forwarded until they are captured.
	assign tile_id_eff = (load_q == LD_TILE) ? ram_rdata : tile_id_q;
	assign row_lo_eff  = (load_q == LD_LOW)  ? ram_rdata : row_lo_q;
	assign row_hi_eff  = (load_q == LD_HIGH) ? ram_rdata : row_hi_q;

	// Window trigger, applied before the fetcher advances.
	assign win_start_x = (win_x_q < WIN_X_OFFSET) ? 8'd0 : win_x_q - WIN_X_OFFSET;
	assign win_trigger = (cmd == CMD_FETCH_TICK) & ~window_on_q & win_enable_q &
		(line_y >= win_y_q) & (screen_x == win_start_x);

	assign phase_e   = win_trigger ? PH_TILE : phase_q;
	assign pos_e     = win_trigger ? 8'd0 : fetch_pos_q;
	assign count_e   = win_trigger ? '0 : count_q;
	assign startup_e = win_trigger ? 2'd0 : startup_q;

	// Map row: scrolled scan line for the background, window counter otherwise.
	assign bg_line  = scroll_y_q + line_y;
	assign map_line = (window_on_q | win_trigger) ? window_row : bg_line;
	assign map_high = (window_on_q | win_trigger) ? win_map_high_q : bg_map_high_q;

	// Signed tile ids address around 0x1000; unsigned ones start at zero.
	assign tile_hi_bit = ~unsigned_tile_data_q & ~tile_id_eff[7];

	// A startup push is withheld while more than half the queue is full.
	assign startup_push = (startup_e != 2'd0) &&
		(count_e <= (FIFO_AW + 1)'(FIFO_DEPTH - TILE_PIXELS));

	// Command decode and fetcher step.
	always_comb begin
		ram_we        = 1'b0;
		ram_re        = 1'b0;
		ram_addr      = mem_addr;
		load_d        = LD_NONE;
		push_en       = 1'b0;
		tile_row_we   = 1'b0;
		tile_row_d    = map_line[2:0];
		phase_d       = phase_q;
		window_on_d   = window_on_q;
		fetch_pos_d   = fetch_pos_q;
		head_d        = head_q;
		count_d       = count_q;
		startup_d     = startup_q;
		pixel_d       = 2'd0;
		pixel_valid_d = 1'b0;
		pop_empty_d   = 1'b0;
		case (cmd)
			CMD_FETCH_TICK: begin
				window_on_d = window_on_q | win_trigger;
				fetch_pos_d = pos_e;
				count_d     = count_e;
				startup_d   = startup_e;
				phase_d     = phase_e + 3'd1;
				case (phase_e)
					PH_TILE: begin
						ram_re      = 1'b1;
						ram_addr    = {MAP_REGION, map_high, map_line[7:3], pos_e[7:3]};
						load_d      = LD_TILE;
						tile_row_we = 1'b1;
						fetch_pos_d = pos_e + 8'(TILE_PIXELS);
					end
					PH_LOW: begin
						ram_re   = 1'b1;
						ram_addr = {tile_hi_bit, tile_id_eff, tile_row_q, 1'b0};
						load_d   = LD_LOW;
					end
					PH_HIGH: begin
						ram_re   = 1'b1;
						ram_addr = {tile_hi_bit, tile_id_eff, tile_row_q, 1'b1};
						load_d   = LD_HIGH;
					end
					PH_PUSH: begin
						phase_d = phase_e;
						if (startup_push || count_e == '0) begin
							push_en = 1'b1;
							phase_d = PH_TILE;
							count_d = count_e + (FIFO_AW + 1)'(TILE_PIXELS);
						end
						if (startup_push) begin
							startup_d = startup_e - 2'd1;
						end
					end
					default: begin
					end
				endcase
			end
			CMD_PIXEL_POP: begin
				if (count_q == '0) begin
					pop_empty_d = 1'b1;
				end else begin
					pixel_d       = fifo_q[head_q];
					pixel_valid_d = 1'b1;
					head_d        = head_q + 1'b1;
					count_d       = count_q - 1'b1;
				end
			end
			CMD_VRAM_WRITE: begin
				ram_we = 1'b1;
			end
			CMD_LINE_START: begin
				fetch_pos_d = start_pos;
				startup_d   = startup_count;
				phase_d     = PH_TILE;
				window_on_d = 1'b0;
				head_d      = '0;
				count_d     = '0;
			end
			default: begin
			end
		endcase
		if (!accept) begin
			ram_we = 1'b0;
			ram_re = 1'b0;
		end
	end

	tbpf_ram #(
		.WIDTH(8),
		.DEPTH(VRAM_BYTES)
	) u_vram (
		.clk   (clk),
		.we    (ram_we),
		.re    (ram_re),
		.addr  (ram_addr),
		.wdata (mem_data),
		.rdata (ram_rdata)
	);

	// Configuration writes; indexes past the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bg_map_high_q        <= 1'b0;
			win_map_high_q       <= 1'b0;
			win_enable_q         <= 1'b0;
			unsigned_tile_data_q <= 1'b1;
			scroll_y_q           <= 8'd0;
			win_y_q              <= 8'd0;
			win_x_q              <= 8'd0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_BG_MAP_HIGH:        bg_map_high_q        <= cfg_data[0];
				REG_WIN_MAP_HIGH:       win_map_high_q       <= cfg_data[0];
				REG_WIN_ENABLE:         win_enable_q         <= cfg_data[0];
				REG_UNSIGNED_TILE_DATA: unsigned_tile_data_q <= cfg_data[0];
				REG_SCROLL_Y:           scroll_y_q           <= cfg_data;
				REG_WIN_Y:              win_y_q              <= cfg_data;
				REG_WIN_X:              win_x_q              <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Fetcher control state and the result handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_TILE;
			window_on_q    <= 1'b0;
			fetch_pos_q    <= 8'd0;
			head_q         <= '0;
			count_q        <= '0;
			startup_q      <= 2'd0;
			load_q         <= LD_NONE;
			result_valid_q <= 1'b0;
		end else begin
			load_q <= accept ? load_d : LD_NONE;
			if (accept) begin
				phase_q        <= phase_d;
				window_on_q    <= window_on_d;
				fetch_pos_q    <= fetch_pos_d;
				head_q         <= head_d;
				count_q        <= count_d;
				startup_q      <= startup_d;
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// Fetched bytes, tile row, queue entries and result payload.
	always_ff @(posedge clk) begin
		if (accept && cmd == CMD_LINE_START) begin
			tile_id_q <= 8'd0;
		end else begin
			tile_id_q <= tile_id_eff;
		end
		row_lo_q <= row_lo_eff;
		row_hi_q <= row_hi_eff;
		if (accept && tile_row_we) begin
			tile_row_q <= tile_row_d;
		end
		if (accept && push_en) begin
			for (int i = 0; i < TILE_PIXELS; i++) begin
				fifo_q[head_q + count_e[FIFO_AW-1:0] + FIFO_AW'(i)] <=
					{row_hi_eff[TILE_PIXELS-1-i], row_lo_eff[TILE_PIXELS-1-i]};
			end
		end
		if (accept) begin
			pixel_q       <= pixel_d;
			pixel_valid_q <= pixel_valid_d;
			pop_empty_q   <= pop_empty_d;
		end
	end

	assign result_valid = result_valid_q;
	assign pixel        = pixel_q;
	assign pixel_valid  = pixel_valid_q;
	assign pop_empty    = pop_empty_q;
	assign fifo_level   = count_q;
	assign in_window    = window_on_q;
	assign fetch_phase  = phase_q;

endmodule
